/* src/entity_id_allocator_defines.svh */
// assertion macros shared by the entity id allocator modules
`ifndef ENTITY_ID_ALLOCATOR_DEFINES_SVH
`define ENTITY_ID_ALLOCATOR_DEFINES_SVH

`ifndef NO_ASSERTIONS
`define EIA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
`define EIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define EIA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg)
`define EIA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg)
`endif

`endif

/* src/eia_pkg.sv */
// shared types and codes of the entity id allocator
`default_nettype none

package eia_pkg;

    localparam int ID_PORT_W  = 10;
    localparam int SIG_PORT_W = 32;

    localparam logic [1:0] FN_CREATE  = 2'd0;
    localparam logic [1:0] FN_DESTROY = 2'd1;
    localparam logic [1:0] FN_SET     = 2'd2;
    localparam logic [1:0] FN_GET     = 2'd3;

    localparam logic [1:0] STAT_OK    = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_RANGE = 2'd2;
    localparam logic [1:0] STAT_EMPTY = 2'd3;

    typedef struct packed {
        logic capture;
        logic clear;
        logic read;
        logic exec;
    } t_eia_cmd;

    typedef struct packed {
        logic clear_last;
    } t_eia_sts;

endpackage

`default_nettype wire

/* src/eia_ctrl.sv */
// controller state machine of the entity id allocator
`default_nettype none
`include "entity_id_allocator_defines.svh"

module eia_ctrl
    import eia_pkg::*;
(
    input  wire logic     i_clk,
    input  wire logic     i_rst_n,
    input  wire logic     start,
    output logic          busy,
    input  wire t_eia_sts i_sts,
    output t_eia_cmd      o_cmd
);

    localparam logic [1:0] S_CLEAR = 2'd0;
    localparam logic [1:0] S_IDLE  = 2'd1;
    localparam logic [1:0] S_READ  = 2'd2;
    localparam logic [1:0] S_EXEC  = 2'd3;

    logic [1:0] r_state;
    logic [1:0] n_state;

    always_comb begin
        n_state = r_state;
        case (r_state)
            S_CLEAR: begin
                if (i_sts.clear_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (start) begin
                    n_state = S_READ;
                end
            end
            S_READ: begin
                n_state = S_EXEC;
            end
            S_EXEC: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_CLEAR;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    assign busy          = (r_state != S_IDLE);
    assign o_cmd.capture = (r_state == S_IDLE) && start;
    assign o_cmd.clear   = (r_state == S_CLEAR);
    assign o_cmd.read    = (r_state == S_READ);
    assign o_cmd.exec    = (r_state == S_EXEC);

    `EIA_ASSERT_NEXT(a_accept_reads, i_clk, i_rst_n, start && !busy, r_state == S_READ, "transfer accepted without a memory read")
    `EIA_ASSERT_NEXT(a_exec_returns, i_clk, i_rst_n, o_cmd.exec, !busy, "busy held after execute")

endmodule

`default_nettype wire

/* src/eia_datapath.sv */
// free list, signature store and result registers of the entity id allocator
`default_nettype none
`include "entity_id_allocator_defines.svh"

module eia_datapath
    import eia_pkg::*;
#(
    parameter int ENTITY_COUNT   = 1024,
    parameter int SIGNATURE_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire t_eia_cmd              i_cmd,
    output t_eia_sts                   o_sts,
    input  wire logic [1:0]            i_func,
    input  wire logic [ID_PORT_W-1:0]  i_entity_id,
    input  wire logic [SIG_PORT_W-1:0] i_signature_in,
    output logic                       o_strobe,
    output logic [ID_PORT_W-1:0]       o_id_out,
    output logic [SIG_PORT_W-1:0]      o_signature_out,
    output logic [1:0]                 o_status
);

    localparam int ID_W  = $clog2(ENTITY_COUNT);
    localparam int CNT_W = $clog2(ENTITY_COUNT + 1);
    localparam int SIG_W = (SIGNATURE_BITS < SIG_PORT_W) ? SIGNATURE_BITS : SIG_PORT_W;
    localparam logic [ID_W-1:0]  LAST_POS = ID_W'(ENTITY_COUNT - 1);
    localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(ENTITY_COUNT);

    // memories
    logic [ID_W-1:0]  r_queue   [ENTITY_COUNT];
    logic [SIG_W-1:0] r_sig_mem [ENTITY_COUNT];

    // request
    logic [1:0]            r_func;
    logic [ID_PORT_W-1:0]  r_id;
    logic [SIG_PORT_W-1:0] r_sig;

    // free list pointers and counters
    logic [ID_W-1:0]  r_head, n_head;
    logic [ID_W-1:0]  r_tail, n_tail;
    logic             r_wrapped, n_wrapped;
    logic [CNT_W-1:0] r_count, n_count;
    logic [ID_W-1:0]  r_clr_addr;

    // read data
    logic [ID_W-1:0]  r_q_rd;
    logic             r_q_written;
    logic [SIG_W-1:0] r_s_rd;

    // results
    logic                  r_strobe;
    logic [ID_PORT_W-1:0]  r_id_out, n_id_out;
    logic [SIG_PORT_W-1:0] r_sig_out, n_sig_out;
    logic [1:0]            r_status, n_status;

    logic             in_range;
    logic [ID_W-1:0]  sig_addr;
    logic [ID_W-1:0]  head_id;
    logic             q_we;
    logic             sig_we;
    logic [ID_W-1:0]  sig_wa;
    logic [SIG_W-1:0] sig_wd;

    assign in_range = (32'(r_id) < 32'(ENTITY_COUNT));
    assign sig_addr = ID_W'(r_id);
    // an entry the tail has not yet passed still holds its reset identity
    assign head_id  = r_q_written ? r_q_rd : r_head;
    assign o_sts.clear_last = (r_clr_addr == LAST_POS);

    always_comb begin
        n_head    = r_head;
        n_tail    = r_tail;
        n_wrapped = r_wrapped;
        n_count   = r_count;
        n_id_out  = '0;
        n_sig_out = '0;
        n_status  = STAT_OK;
        q_we      = 1'b0;
        sig_we    = 1'b0;
        sig_wa    = sig_addr;
        sig_wd    = '0;
        if (i_cmd.clear) begin
            sig_we = 1'b1;
            sig_wa = r_clr_addr;
        end
        if (i_cmd.exec) begin
            if (r_func == FN_CREATE) begin
                if (r_count == FULL_CNT) begin
                    n_status = STAT_FULL;
                end else begin
                    n_id_out = ID_PORT_W'(head_id);
                    n_head   = (r_head == LAST_POS) ? '0 : r_head + 1'b1;
                    n_count  = r_count + 1'b1;
                end
            end else if (!in_range) begin
                n_status = STAT_RANGE;
            end else begin
                case (r_func)
                    FN_DESTROY: begin
                        if (r_count == '0) begin
                            n_status = STAT_EMPTY;
                        end else begin
                            sig_we  = 1'b1;
                            q_we    = 1'b1;
                            n_count = r_count - 1'b1;
                            if (r_tail == LAST_POS) begin
                                n_tail    = '0;
                                n_wrapped = 1'b1;
                            end else begin
                                n_tail = r_tail + 1'b1;
                            end
                        end
                    end
                    FN_SET: begin
                        sig_we = 1'b1;
                        sig_wd = SIG_W'(r_sig);
                    end
                    FN_GET: begin
                        n_sig_out = SIG_PORT_W'(r_s_rd);
                    end
                    default: begin
                        n_status = STAT_OK;
                    end
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (q_we) begin
            r_queue[r_tail] <= ID_W'(r_id);
        end
        if (sig_we) begin
            r_sig_mem[sig_wa] <= sig_wd;
        end
        if (i_cmd.read) begin
            r_q_rd      <= r_queue[r_head];
            r_q_written <= r_wrapped || (r_head < r_tail);
            r_s_rd      <= r_sig_mem[sig_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_func <= i_func;
            r_id   <= i_entity_id;
            r_sig  <= i_signature_in;
        end
        if (i_cmd.exec) begin
            r_id_out  <= n_id_out;
            r_sig_out <= n_sig_out;
            r_status  <= n_status;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_head     <= '0;
            r_tail     <= '0;
            r_wrapped  <= 1'b0;
            r_count    <= '0;
            r_clr_addr <= '0;
            r_strobe   <= 1'b0;
        end else begin
            r_head    <= n_head;
            r_tail    <= n_tail;
            r_wrapped <= n_wrapped;
            r_count   <= n_count;
            r_strobe  <= i_cmd.exec;
            if (i_cmd.clear) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    assign o_strobe        = r_strobe;
    assign o_id_out        = r_id_out;
    assign o_signature_out = r_sig_out;
    assign o_status        = r_status;

    `EIA_ASSERT_SAME(a_count_bound, i_clk, i_rst_n, 1'b1, r_count <= FULL_CNT, "in-use count above capacity")
    `EIA_ASSERT_NEXT(a_create_count, i_clk, i_rst_n, i_cmd.exec && r_func == FN_CREATE && r_count != FULL_CNT, r_count == CNT_W'($past(r_count) + 1'b1) && o_status == STAT_OK, "create did not take an identifier")
    `EIA_ASSERT_SAME(a_exec_quiet, i_clk, i_rst_n, i_cmd.clear, !i_cmd.exec && !q_we, "free list touched during clearing pass")

endmodule

`default_nettype wire

/* src/entity_id_allocator.sv */
// top level of the entity id allocator: fifo free list and signature store
//
// channel   direction  transfer when        payload
// command   in         start && !busy       i_func, i_entity_id, i_signature_in
// result    out        o_strobe (one cycle) o_id_out, o_signature_out, o_status
//
// each command runs through capture, memory read and execute; the result
// strobe rises in the cycle after execute, when the next command may already
// be taken. after reset busy stays high while the signature store is swept
// to zero. results cannot be held off by the receiver.
`default_nettype none

module entity_id_allocator
    import eia_pkg::*;
#(
    parameter int ENTITY_COUNT   = 1024,
    parameter int SIGNATURE_BITS = 32
) (
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  start,
    output logic                       busy,
    input  wire logic [1:0]            i_func,
    input  wire logic [ID_PORT_W-1:0]  i_entity_id,
    input  wire logic [SIG_PORT_W-1:0] i_signature_in,
    output logic                       o_strobe,
    output logic [ID_PORT_W-1:0]       o_id_out,
    output logic [SIG_PORT_W-1:0]      o_signature_out,
    output logic [1:0]                 o_status
);

    t_eia_cmd cmd;
    t_eia_sts sts;

    eia_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_cmd   (cmd)
    );

    eia_datapath #(
        .ENTITY_COUNT   (ENTITY_COUNT),
        .SIGNATURE_BITS (SIGNATURE_BITS)
    ) u_datapath (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd           (cmd),
        .o_sts           (sts),
        .i_func          (i_func),
        .i_entity_id     (i_entity_id),
        .i_signature_in  (i_signature_in),
        .o_strobe        (o_strobe),
        .o_id_out        (o_id_out),
        .o_signature_out (o_signature_out),
        .o_status        (o_status)
    );

endmodule

`default_nettype wire
